// File: src/sdinit_pkg.sv
// ----------------------------------------------------------------------------
// sdinit_pkg: shared types and constants of the card init sequencer
// Payload structs, phase and code enums, command indexes and OCR masks.
// ----------------------------------------------------------------------------
package sdinit_pkg;

  localparam int unsigned RETRY_W = 7;
  localparam int unsigned CAP_W   = 42;
  localparam int unsigned NBLK_W  = 33;

  // request item
  typedef struct packed {
    logic [1:0]  action;
    logic        cmd_failed;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] ext_sector_count;
    logic [31:0] block_index;
  } req_t;

  // result item as seen on the port
  typedef struct packed {
    logic [1:0]        status;
    logic [5:0]        cmd_index;
    logic [31:0]       cmd_argument;
    logic [2:0]        resp_kind;
    logic [1:0]        data_direction;
    logic [15:0]       data_bytes;
    logic [2:0]        card_version;
    logic              is_high_capacity;
    logic [NBLK_W-1:0] block_count;
    logic [CAP_W-1:0]  capacity_bytes;
  } rsp_t;

  // result as produced by the control stage, before the capacity product
  typedef struct packed {
    logic [1:0]        status;
    logic [5:0]        cmd_index;
    logic [31:0]       cmd_argument;
    logic [2:0]        resp_kind;
    logic [1:0]        data_direction;
    logic [15:0]       data_bytes;
    logic [2:0]        card_version;
    logic              is_high_capacity;
    logic [NBLK_W-1:0] block_count;
    logic [3:0]        block_size_log2;
  } res_t;

  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_READ     = 2'd2,
    ACT_WRITE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_ISSUED  = 2'd0,
    ST_READY   = 2'd1,
    ST_FAILED  = 2'd2,
    ST_REFUSED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RK_NONE = 3'd0,
    RK_R1   = 3'd1,
    RK_R2   = 3'd2,
    RK_R3   = 3'd3,
    RK_R6   = 3'd4,
    RK_R7   = 3'd5
  } resp_kind_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_READ  = 2'd1,
    DIR_WRITE = 2'd2
  } dir_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_CMD55  = 4'd3,
    PH_ACMD41 = 4'd4,
    PH_CMD1   = 4'd5,
    PH_CMD2   = 4'd6,
    PH_CMD3   = 4'd7,
    PH_CMD9   = 4'd8,
    PH_CMD7   = 4'd9,
    PH_EXT    = 4'd10,
    PH_READY  = 4'd11,
    PH_FAILED = 4'd12
  } phase_e;

  // card version codes
  localparam logic [2:0] VER_MMC_UNKNOWN = 3'd0;
  localparam logic [2:0] VER_MMC_1_2     = 3'd1;
  localparam logic [2:0] VER_SD1         = 3'd6;
  localparam logic [2:0] VER_SD2         = 3'd7;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_SEND_OP_COND = 6'd1;
  localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA     = 6'd3;
  localparam logic [5:0] CMD_SELECT       = 6'd7;
  localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
  localparam logic [5:0] CMD_SEND_EXT_CSD = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
  localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] ACMD_SD_OP_COND  = 6'd41;
  localparam logic [5:0] CMD_APP          = 6'd55;

  // ocr and argument masks
  localparam logic [31:0] OCR_BUSY_BIT    = 32'h8000_0000;
  localparam logic [31:0] OCR_HCS_BIT     = 32'h4000_0000;
  localparam logic [31:0] OCR_VOLT_MASK   = 32'h007F_FF80;
  localparam logic [31:0] OCR_ACCESS_BITS = 32'h6000_0000;
  localparam logic [23:0] HOST_VOLT_MASK  = 24'hFF_8000;
  localparam logic [23:0] HOST_WIN_RESET  = 24'hFF_8000;
  localparam logic [7:0]  IF_COND_PATTERN = 8'hAA;
  localparam logic [31:0] IF_COND_VHS     = 32'h0000_0100;
  localparam logic [15:0] EXT_CSD_BYTES   = 16'd512;
  localparam logic [3:0]  BLK_LOG2_RESET  = 4'd9;

endpackage

// File: src/sdinit_req_if.sv
// ----------------------------------------------------------------------------
// sdinit_req_if: request channel
// Valid/ready channel carrying one request item per transfer.
// ----------------------------------------------------------------------------
interface sdinit_req_if
  import sdinit_pkg::*;
();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/sdinit_rsp_if.sv
// ----------------------------------------------------------------------------
// sdinit_rsp_if: result channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface sdinit_rsp_if
  import sdinit_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/sdinit_cfg_if.sv
// ----------------------------------------------------------------------------
// sdinit_cfg_if: configuration write channel
// Valid/ready channel carrying the host voltage window register value.
// ----------------------------------------------------------------------------
interface sdinit_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/sdinit_in_reg.sv
// ----------------------------------------------------------------------------
// sdinit_in_reg: request input register
// Holds one accepted request until the control stage takes it.
// ----------------------------------------------------------------------------
module sdinit_in_reg
  import sdinit_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  sdinit_req_if.sink    req,
  input  logic          take_i,
  output logic          valid_o,
  output req_t          item_o
);

  logic valid_q;
  req_t item_q;

  // free when empty or when the held item moves on this cycle
  assign req.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req.ready) begin
      valid_q <= req.valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      item_q <= req.data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/sdinit_ctrl.sv
// ----------------------------------------------------------------------------
// sdinit_ctrl: init sequencer state and command selection
// Keeps the card record and picks the next command for each request item.
// ----------------------------------------------------------------------------
module sdinit_ctrl
  import sdinit_pkg::*;
#(
  parameter int unsigned SD_OP_COND_TRIES  = 11,
  parameter int unsigned MMC_OP_COND_TRIES = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  req_t        item_i,
  input  logic [23:0] win_i,
  output res_t        res_o
);

  localparam logic [RETRY_W-1:0] SD_TRIES  = RETRY_W'(SD_OP_COND_TRIES);
  localparam logic [RETRY_W-1:0] MMC_TRIES = RETRY_W'(MMC_OP_COND_TRIES);

  phase_e              phase_q, phase_d;
  logic [31:0]         ocr_q, ocr_d;
  logic [15:0]         rca_q, rca_d;
  logic [2:0]          ver_q, ver_d;
  logic                hc_q, hc_d;
  logic [RETRY_W-1:0]  retry_q, retry_d;
  logic [3:0]          bsl_q, bsl_d;
  logic [NBLK_W-1:0]   nblk_q, nblk_d;

  logic [31:0]         win_ext;
  logic [31:0]         win_volt;
  logic                is_sd;
  logic [RETRY_W-1:0]  retry_inc;
  logic [3:0]          csd_ver;
  logic [21:0]         csize_hc;
  logic [11:0]         csize_sc;
  logic [2:0]          cmult;
  logic [31:0]         w0;

  // result fields other than the card record
  logic [1:0]          st;
  logic [5:0]          cmd;
  logic [31:0]         arg;
  logic [2:0]          rk;
  logic [1:0]          dir;
  logic [15:0]         bytes;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ocr_q   <= '0;
      rca_q   <= '0;
      ver_q   <= VER_MMC_UNKNOWN;
      hc_q    <= 1'b0;
      retry_q <= '0;
      bsl_q   <= BLK_LOG2_RESET;
      nblk_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      ocr_q   <= ocr_d;
      rca_q   <= rca_d;
      ver_q   <= ver_d;
      hc_q    <= hc_d;
      retry_q <= retry_d;
      bsl_q   <= bsl_d;
      nblk_q  <= nblk_d;
    end
  end

  // helpers
  assign w0        = item_i.resp_word0;
  assign win_ext   = {8'h00, win_i};
  assign win_volt  = {8'h00, win_i & HOST_VOLT_MASK};
  assign is_sd     = (ver_q >= VER_SD1);
  assign retry_inc = retry_q + RETRY_W'(1);
  assign csd_ver   = w0[29:26];
  assign csize_hc  = {item_i.resp_word1[5:0], item_i.resp_word2[31:16]};
  assign csize_sc  = {item_i.resp_word1[9:0], item_i.resp_word2[31:30]};
  assign cmult     = item_i.resp_word2[17:15];

  // next state and result
  always_comb begin
    phase_d = phase_q;
    ocr_d   = ocr_q;
    rca_d   = rca_q;
    ver_d   = ver_q;
    hc_d    = hc_q;
    retry_d = retry_q;
    bsl_d   = bsl_q;
    nblk_d  = nblk_q;
    st      = ST_ISSUED;
    cmd     = CMD_GO_IDLE;
    arg     = '0;
    rk      = RK_NONE;
    dir     = DIR_NONE;
    bytes   = '0;

    case (item_i.action)
      ACT_START: begin
        ocr_d   = '0;
        rca_d   = '0;
        ver_d   = VER_MMC_UNKNOWN;
        hc_d    = 1'b0;
        retry_d = '0;
        bsl_d   = BLK_LOG2_RESET;
        nblk_d  = '0;
        phase_d = PH_CMD0;
      end

      ACT_COMPLETE: begin
        case (phase_q)
          PH_CMD0: begin
            if (item_i.cmd_failed) begin
              phase_d = PH_FAILED;
              st      = ST_FAILED;
            end else begin
              phase_d = PH_CMD8;
              cmd     = CMD_SEND_IF_COND;
              arg     = (((win_i & HOST_VOLT_MASK) != '0) ? IF_COND_VHS : '0)
                        | {24'h0, IF_COND_PATTERN};
              rk      = RK_R7;
            end
          end

          // interface condition errors are ignored
          PH_CMD8: begin
            if (!item_i.cmd_failed && (w0[7:0] == IF_COND_PATTERN)) begin
              ver_d = VER_SD2;
            end
            retry_d = '0;
            phase_d = PH_CMD55;
            cmd     = CMD_APP;
            rk      = RK_R1;
          end

          PH_CMD55: begin
            if (item_i.cmd_failed) begin
              retry_d = '0;
              phase_d = PH_CMD1;
              cmd     = CMD_SEND_OP_COND;
              rk      = RK_R3;
            end else begin
              phase_d = PH_ACMD41;
              cmd     = ACMD_SD_OP_COND;
              arg     = win_volt | ((ver_q == VER_SD2) ? OCR_HCS_BIT : '0);
              rk      = RK_R3;
            end
          end

          PH_ACMD41: begin
            if (item_i.cmd_failed) begin
              retry_d = '0;
              phase_d = PH_CMD1;
              cmd     = CMD_SEND_OP_COND;
              rk      = RK_R3;
            end else if ((w0 & OCR_BUSY_BIT) != '0) begin
              if (ver_q != VER_SD2) begin
                ver_d = VER_SD1;
              end
              ocr_d   = w0;
              hc_d    = ((w0 & OCR_HCS_BIT) != '0);
              rca_d   = '0;
              phase_d = PH_CMD2;
              cmd     = CMD_ALL_SEND_CID;
              rk      = RK_R2;
            end else if (retry_inc >= SD_TRIES) begin
              // out of sd tries, fall back to mmc
              retry_d = '0;
              phase_d = PH_CMD1;
              cmd     = CMD_SEND_OP_COND;
              rk      = RK_R3;
            end else begin
              retry_d = retry_inc;
              phase_d = PH_CMD55;
              cmd     = CMD_APP;
              rk      = RK_R1;
            end
          end

          PH_CMD1: begin
            if (item_i.cmd_failed) begin
              phase_d = PH_FAILED;
              st      = ST_FAILED;
            end else begin
              ocr_d   = w0;
              retry_d = retry_inc;
              if ((w0 & OCR_BUSY_BIT) != '0) begin
                hc_d    = ((w0 & OCR_HCS_BIT) != '0);
                ver_d   = VER_MMC_UNKNOWN;
                rca_d   = 16'd1;
                phase_d = PH_CMD2;
                cmd     = CMD_ALL_SEND_CID;
                rk      = RK_R2;
              end else if (retry_inc >= MMC_TRIES) begin
                phase_d = PH_FAILED;
                st      = ST_FAILED;
              end else begin
                phase_d = PH_CMD1;
                cmd     = CMD_SEND_OP_COND;
                arg     = OCR_HCS_BIT | (win_ext & w0 & OCR_VOLT_MASK)
                          | (w0 & OCR_ACCESS_BITS);
                rk      = RK_R3;
              end
            end
          end

          PH_CMD2: begin
            if (item_i.cmd_failed) begin
              phase_d = PH_FAILED;
              st      = ST_FAILED;
            end else begin
              phase_d = PH_CMD3;
              cmd     = CMD_SEND_RCA;
              arg     = {rca_q, 16'h0000};
              rk      = RK_R6;
            end
          end

          PH_CMD3: begin
            if (item_i.cmd_failed) begin
              phase_d = PH_FAILED;
              st      = ST_FAILED;
            end else begin
              if (is_sd) begin
                rca_d = w0[31:16];
              end
              phase_d = PH_CMD9;
              cmd     = CMD_SEND_CSD;
              arg     = {(is_sd ? w0[31:16] : rca_q), 16'h0000};
              rk      = RK_R2;
            end
          end

          // csd decode
          PH_CMD9: begin
            if (item_i.cmd_failed) begin
              phase_d = PH_FAILED;
              st      = ST_FAILED;
            end else begin
              if (ver_q == VER_MMC_UNKNOWN) begin
                ver_d = (csd_ver <= 4'd4) ? 3'(csd_ver + 4'd1) : VER_MMC_1_2;
              end
              if (hc_q) begin
                bsl_d  = BLK_LOG2_RESET;
                nblk_d = (NBLK_W'(csize_hc) + NBLK_W'(1)) << 10;
              end else begin
                bsl_d  = item_i.resp_word1[19:16];
                nblk_d = (NBLK_W'(csize_sc) + NBLK_W'(1)) << (4'(cmult) + 4'd2);
              end
              phase_d = PH_CMD7;
              cmd     = CMD_SELECT;
              arg     = {rca_q, 16'h0000};
              rk      = RK_R1;
            end
          end

          PH_CMD7: begin
            if (item_i.cmd_failed) begin
              phase_d = PH_FAILED;
              st      = ST_FAILED;
            end else if (is_sd) begin
              phase_d = PH_READY;
              st      = ST_READY;
            end else begin
              phase_d = PH_EXT;
              cmd     = CMD_SEND_EXT_CSD;
              rk      = RK_R1;
              dir     = DIR_READ;
              bytes   = EXT_CSD_BYTES;
            end
          end

          PH_EXT: begin
            if (item_i.cmd_failed) begin
              phase_d = PH_FAILED;
              st      = ST_FAILED;
            end else begin
              if (item_i.ext_sector_count != '0) begin
                nblk_d = NBLK_W'(item_i.ext_sector_count);
              end
              phase_d = PH_READY;
              st      = ST_READY;
            end
          end

          PH_READY:  st = ST_READY;
          PH_FAILED: st = ST_FAILED;
          default:   st = ST_REFUSED;
        endcase
      end

      // read and write requests
      default: begin
        if (phase_q == PH_READY) begin
          cmd   = (item_i.action == ACT_READ) ? CMD_READ_SINGLE : CMD_WRITE_SINGLE;
          arg   = hc_q ? item_i.block_index : (item_i.block_index << bsl_q);
          rk    = RK_R1;
          dir   = (item_i.action == ACT_READ) ? DIR_READ : DIR_WRITE;
          bytes = 16'd1 << bsl_q;
        end else begin
          st = ST_REFUSED;
        end
      end
    endcase

    // no command fields unless a command goes out
    if (st != ST_ISSUED) begin
      cmd   = '0;
      arg   = '0;
      rk    = RK_NONE;
      dir   = DIR_NONE;
      bytes = '0;
    end
  end

  assign res_o.status           = st;
  assign res_o.cmd_index        = cmd;
  assign res_o.cmd_argument     = arg;
  assign res_o.resp_kind        = rk;
  assign res_o.data_direction   = dir;
  assign res_o.data_bytes       = bytes;
  assign res_o.card_version     = ver_d;
  assign res_o.is_high_capacity = hc_d;
  assign res_o.block_count      = nblk_d;
  assign res_o.block_size_log2  = bsl_d;

endmodule

// File: src/sdinit_out_reg.sv
// ----------------------------------------------------------------------------
// sdinit_out_reg: result register
// Holds one result until the receiver takes it; forms the capacity field.
// ----------------------------------------------------------------------------
module sdinit_out_reg
  import sdinit_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  res_t          res_i,
  output logic          free_o,
  sdinit_rsp_if.source  rsp
);

  logic                  valid_q;
  res_t                  res_q;
  logic [CAP_W+5:0]      cap_wide;

  // free when empty or when the held result is taken this cycle
  assign free_o = !valid_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

  // capacity, saturated to the field width
  assign cap_wide = (CAP_W+6)'(res_q.block_count) << res_q.block_size_log2;

  assign rsp.valid                  = valid_q;
  assign rsp.data.status            = res_q.status;
  assign rsp.data.cmd_index         = res_q.cmd_index;
  assign rsp.data.cmd_argument      = res_q.cmd_argument;
  assign rsp.data.resp_kind         = res_q.resp_kind;
  assign rsp.data.data_direction    = res_q.data_direction;
  assign rsp.data.data_bytes        = res_q.data_bytes;
  assign rsp.data.card_version      = res_q.card_version;
  assign rsp.data.is_high_capacity  = res_q.is_high_capacity;
  assign rsp.data.block_count       = res_q.block_count;
  assign rsp.data.capacity_bytes    = (cap_wide[CAP_W+5:CAP_W] != '0) ? '1
                                      : cap_wide[CAP_W-1:0];

endmodule

// File: src/sd_mmc_card_init_sequencer_unit.sv
// ----------------------------------------------------------------------------
// sd_mmc_card_init_sequencer_unit: host-side card bring-up sequencer
// Turns start, completion and block request items into card commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  valid/ready request channel: start, command completed (with error
//          flag and response words), read or write block request.
//   rsp_o  valid/ready result channel: one result per request, carrying the
//          next command (index, argument, response kind, data phase) or a
//          ready / failed / refused status, plus the current card record.
//   cfg_i  write channel for the host voltage window; always ready, write
//          only while no request is in flight.
// A request passes through the input register, then the decode and state
// update feeding the result register, which holds the result until taken.
// Throughput is one item per cycle while the receiver is ready; the card record updates once per item.
// A request is taken while a finished result still waits, as long as the
// input register is free or moves on in the same cycle.
// When the receiver stalls the result holds, then the input register fills
// and req_i.ready drops.
// Reset empties both registers, puts the sequencer in idle and loads the
// default voltage window; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sd_mmc_card_init_sequencer_unit
  import sdinit_pkg::*;
#(
  parameter int unsigned SD_OP_COND_TRIES  = 11,
  parameter int unsigned MMC_OP_COND_TRIES = 100
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sdinit_cfg_if.sink    cfg_i,
  sdinit_req_if.sink    req_i,
  sdinit_rsp_if.source  rsp_o
);

  logic [23:0] win_q;
  logic        item_valid;
  req_t        item;
  logic        out_free;
  logic        fire;
  res_t        res;

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= HOST_WIN_RESET;
    end else if (cfg_i.valid) begin
      win_q <= cfg_i.data;
    end
  end

  // item moves from input register to result register
  assign fire = item_valid && out_free;

  sdinit_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_i),
    .take_i  (fire),
    .valid_o (item_valid),
    .item_o  (item)
  );

  sdinit_ctrl #(
    .SD_OP_COND_TRIES  (SD_OP_COND_TRIES),
    .MMC_OP_COND_TRIES (MMC_OP_COND_TRIES)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .win_i  (win_q),
    .res_o  (res)
  );

  sdinit_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res),
    .free_o (out_free),
    .rsp    (rsp_o)
  );

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the card init sequencer
// Drives start, completion and block request traffic through the request
// channel, mirrors the sequencer state in a local model and checks every
// result field against it, across several host voltage window settings.
// ----------------------------------------------------------------------------
module tb;
  import sdinit_pkg::*;

  localparam int unsigned SD_TRIES           = 11;
  localparam int unsigned MMC_TRIES          = 100;
  localparam int          HOLDOFF_CYCLES     = 80;
  localparam int          STALL_LIMIT        = 1000;
  localparam int          SETTLE_CYCLES      = 8;
  localparam int          MAX_SHOWN          = 10;
  localparam int          EVENTS_PER_SETTING = 175;
  localparam int          N_SETTINGS         = 7;
  localparam logic [63:0] CAP_MAX            = (64'd1 << CAP_W) - 64'd1;

  logic clk_i = 1'b0;
  logic rst_ni;

  sdinit_cfg_if cfg_if ();
  sdinit_req_if req_if ();
  sdinit_rsp_if rsp_if ();

  sd_mmc_card_init_sequencer_unit #(
    .SD_OP_COND_TRIES (SD_TRIES),
    .MMC_OP_COND_TRIES(MMC_TRIES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // host events waiting to be offered, and card results still owed
  req_t host_events[$];
  rsp_t awaited_results[$];

  // local copy of the sequencer state
  logic [23:0] host_window;
  phase_e      card_phase;
  logic [31:0] card_ocr;
  logic [15:0] card_rca;
  logic [2:0]  card_ver;
  logic        card_hc;
  logic [6:0]  op_tries;
  logic [3:0]  card_blk_log2;
  logic [32:0] card_blocks;

  bit gaps_on     = 1'b1;
  bit holdoff_go  = 1'b0;
  int holdoff_cnt = 0;
  int req_gap     = 0;
  int rsp_gap     = 0;
  int req_accepts = 0;
  int req_seen    = 0;
  int stalled     = 0;
  int mismatches  = 0;
  int events_queued = 0;
  int windows_set   = 0;
  int action_tally[4];
  int status_tally[4];

  // result record built from the current card state
  function automatic rsp_t card_record(status_e st, logic [5:0] idx, logic [31:0] arg,
                                       resp_kind_e rk, dir_e dir, logic [15:0] nbytes);
    rsp_t        r;
    logic [63:0] cap;
    cap = {31'd0, card_blocks} << card_blk_log2;
    if (cap > CAP_MAX) cap = CAP_MAX;
    r.status           = st;
    r.cmd_index        = idx;
    r.cmd_argument     = arg;
    r.resp_kind        = rk;
    r.data_direction   = dir;
    r.data_bytes       = nbytes;
    r.card_version     = card_ver;
    r.is_high_capacity = card_hc;
    r.block_count      = card_blocks;
    r.capacity_bytes   = cap[CAP_W-1:0];
    return r;
  endfunction

  function automatic rsp_t issue_cmd(phase_e nxt, logic [5:0] idx, logic [31:0] arg,
                                     resp_kind_e rk);
    card_phase = nxt;
    return card_record(ST_ISSUED, idx, arg, rk, DIR_NONE, 16'd0);
  endfunction

  function automatic rsp_t init_failed();
    card_phase = PH_FAILED;
    return card_record(ST_FAILED, 6'd0, 32'd0, RK_NONE, DIR_NONE, 16'd0);
  endfunction

  function automatic rsp_t fall_back_to_mmc();
    op_tries = 7'd0;
    return issue_cmd(PH_CMD1, CMD_SEND_OP_COND, 32'd0, RK_R3);
  endfunction

  // advance the sequencer model by one host event
  function automatic rsp_t sequencer_step(req_t q);
    rsp_t        r;
    logic        bad;
    logic        is_sd;
    logic [31:0] w0;
    logic [31:0] win;
    logic [31:0] arg;
    logic [21:0] hc_size;
    logic [11:0] sc_size;
    logic [2:0]  c_mult;
    logic [3:0]  csd_ver;
    bad   = q.cmd_failed;
    w0    = q.resp_word0;
    win   = {8'd0, host_window};
    is_sd = (card_ver >= VER_SD1);
    r     = card_record(ST_REFUSED, 6'd0, 32'd0, RK_NONE, DIR_NONE, 16'd0);
    case (action_e'(q.action))
      ACT_START: begin
        card_ocr      = 32'd0;
        card_rca      = 16'd0;
        card_ver      = VER_MMC_UNKNOWN;
        card_hc       = 1'b0;
        op_tries      = 7'd0;
        card_blk_log2 = BLK_LOG2_RESET;
        card_blocks   = 33'd0;
        r = issue_cmd(PH_CMD0, CMD_GO_IDLE, 32'd0, RK_NONE);
      end
      ACT_COMPLETE: begin
        case (card_phase)
          PH_CMD0: begin
            if (bad) r = init_failed();
            else begin
              arg = {24'd0, IF_COND_PATTERN};
              if ((win & {8'd0, HOST_VOLT_MASK}) != 32'd0) arg = arg | IF_COND_VHS;
              r = issue_cmd(PH_CMD8, CMD_SEND_IF_COND, arg, RK_R7);
            end
          end
          // a failed or garbled interface condition is not fatal
          PH_CMD8: begin
            if (!bad && w0[7:0] == IF_COND_PATTERN) card_ver = VER_SD2;
            op_tries = 7'd0;
            r = issue_cmd(PH_CMD55, CMD_APP, 32'd0, RK_R1);
          end
          PH_CMD55: begin
            if (bad) r = fall_back_to_mmc();
            else begin
              arg = win & {8'd0, HOST_VOLT_MASK};
              if (card_ver == VER_SD2) arg = arg | OCR_HCS_BIT;
              r = issue_cmd(PH_ACMD41, ACMD_SD_OP_COND, arg, RK_R3);
            end
          end
          PH_ACMD41: begin
            if (bad) r = fall_back_to_mmc();
            else if ((w0 & OCR_BUSY_BIT) != 32'd0) begin
              if (card_ver != VER_SD2) card_ver = VER_SD1;
              card_ocr = w0;
              card_hc  = ((w0 & OCR_HCS_BIT) != 32'd0);
              card_rca = 16'd0;
              r = issue_cmd(PH_CMD2, CMD_ALL_SEND_CID, 32'd0, RK_R2);
            end else begin
              op_tries = op_tries + 7'd1;
              if (op_tries >= SD_TRIES) r = fall_back_to_mmc();
              else r = issue_cmd(PH_CMD55, CMD_APP, 32'd0, RK_R1);
            end
          end
          PH_CMD1: begin
            if (bad) r = init_failed();
            else begin
              card_ocr = w0;
              op_tries = op_tries + 7'd1;
              if ((w0 & OCR_BUSY_BIT) != 32'd0) begin
                card_hc  = ((w0 & OCR_HCS_BIT) != 32'd0);
                card_ver = VER_MMC_UNKNOWN;
                card_rca = 16'd1;
                r = issue_cmd(PH_CMD2, CMD_ALL_SEND_CID, 32'd0, RK_R2);
              end else if (op_tries >= MMC_TRIES) begin
                r = init_failed();
              end else begin
                arg = OCR_HCS_BIT | (win & card_ocr & OCR_VOLT_MASK) |
                      (card_ocr & OCR_ACCESS_BITS);
                r = issue_cmd(PH_CMD1, CMD_SEND_OP_COND, arg, RK_R3);
              end
            end
          end
          PH_CMD2: begin
            if (bad) r = init_failed();
            else r = issue_cmd(PH_CMD3, CMD_SEND_RCA, {card_rca, 16'd0}, RK_R6);
          end
          PH_CMD3: begin
            if (bad) r = init_failed();
            else begin
              if (is_sd) card_rca = w0[31:16];
              r = issue_cmd(PH_CMD9, CMD_SEND_CSD, {card_rca, 16'd0}, RK_R2);
            end
          end
          // csd decode: structure version, then size by addressing mode
          PH_CMD9: begin
            if (bad) r = init_failed();
            else begin
              if (card_ver == VER_MMC_UNKNOWN) begin
                csd_ver = w0[29:26];
                if (csd_ver <= 4'd4) card_ver = csd_ver[2:0] + 3'd1;
                else card_ver = VER_MMC_1_2;
              end
              if (card_hc) begin
                hc_size       = {q.resp_word1[5:0], q.resp_word2[31:16]};
                card_blk_log2 = BLK_LOG2_RESET;
                card_blocks   = (33'(hc_size) + 33'd1) << 10;
              end else begin
                sc_size       = {q.resp_word1[9:0], q.resp_word2[31:30]};
                c_mult        = q.resp_word2[17:15];
                card_blk_log2 = q.resp_word1[19:16];
                card_blocks   = (33'(sc_size) + 33'd1) << (32'(c_mult) + 2);
              end
              r = issue_cmd(PH_CMD7, CMD_SELECT, {card_rca, 16'd0}, RK_R1);
            end
          end
          PH_CMD7: begin
            if (bad) r = init_failed();
            else if (is_sd) begin
              card_phase = PH_READY;
              r = card_record(ST_READY, 6'd0, 32'd0, RK_NONE, DIR_NONE, 16'd0);
            end else begin
              card_phase = PH_EXT;
              r = card_record(ST_ISSUED, CMD_SEND_EXT_CSD, 32'd0, RK_R1, DIR_READ,
                              EXT_CSD_BYTES);
            end
          end
          PH_EXT: begin
            if (bad) r = init_failed();
            else begin
              if (q.ext_sector_count != 32'd0) card_blocks = {1'b0, q.ext_sector_count};
              card_phase = PH_READY;
              r = card_record(ST_READY, 6'd0, 32'd0, RK_NONE, DIR_NONE, 16'd0);
            end
          end
          PH_READY:  r = card_record(ST_READY, 6'd0, 32'd0, RK_NONE, DIR_NONE, 16'd0);
          PH_FAILED: r = card_record(ST_FAILED, 6'd0, 32'd0, RK_NONE, DIR_NONE, 16'd0);
          default: ;
        endcase
      end
      // block read or write, refused until the card is ready
      default: begin
        if (card_phase == PH_READY) begin
          arg = card_hc ? q.block_index : (q.block_index << card_blk_log2);
          if (action_e'(q.action) == ACT_READ)
            r = card_record(ST_ISSUED, CMD_READ_SINGLE, arg, RK_R1, DIR_READ,
                            16'd1 << card_blk_log2);
          else
            r = card_record(ST_ISSUED, CMD_WRITE_SINGLE, arg, RK_R1, DIR_WRITE,
                            16'd1 << card_blk_log2);
        end
      end
    endcase
    return r;
  endfunction

  function automatic string show_result(rsp_t r);
    return $sformatf({"st=%0d cmd=%0d arg=%h rk=%0d dir=%0d bytes=%0d ver=%0d hc=%0d ",
                      "blocks=%0d cap=%0d"},
                     r.status, r.cmd_index, r.cmd_argument, r.resp_kind, r.data_direction,
                     r.data_bytes, r.card_version, r.is_high_capacity, r.block_count,
                     r.capacity_bytes);
  endfunction

  task automatic push_event(action_e act, logic bad, logic [31:0] w0, logic [31:0] w1,
                            logic [31:0] w2, logic [31:0] ext, logic [31:0] blk);
    req_t q;
    q.action           = act;
    q.cmd_failed       = bad;
    q.resp_word0       = w0;
    q.resp_word1       = w1;
    q.resp_word2       = w2;
    q.ext_sector_count = ext;
    q.block_index      = blk;
    host_events.push_back(q);
    events_queued++;
  endtask

  // completion with random filler in the unused words
  task automatic answer(logic bad, logic [31:0] w0);
    push_event(ACT_COMPLETE, bad, w0, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic logic cmd_error();
    return ($urandom_range(0, 99) < 3);
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 15))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one bring-up attempt from start towards ready, then some block traffic
  task automatic bring_up_card(bit as_sd);
    int          polls;
    logic [31:0] echo;
    push_event(ACT_START, $urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
               $urandom);
    answer(cmd_error(), $urandom);
    echo = $urandom;
    if (as_sd && $urandom_range(0, 2) != 0) echo[7:0] = IF_COND_PATTERN;
    answer($urandom_range(0, 7) == 0, echo);
    if (as_sd) begin
      polls = $urandom_range(0, SD_TRIES - 1);
      for (int i = 0; i < polls; i++) begin
        answer(cmd_error(), $urandom);
        answer(cmd_error(), $urandom & ~OCR_BUSY_BIT);
      end
      answer(cmd_error(), $urandom);
      answer(cmd_error(), $urandom | OCR_BUSY_BIT);
    end else begin
      // leave the sd branch by a rejected app command, a rejected
      // op condition, or by running out of polls
      case ($urandom_range(0, 2))
        0: answer(1'b1, $urandom);
        1: begin
          answer(1'b0, $urandom);
          answer(1'b1, $urandom);
        end
        default: begin
          for (int i = 0; i < SD_TRIES; i++) begin
            answer(1'b0, $urandom);
            answer(1'b0, $urandom & ~OCR_BUSY_BIT);
          end
        end
      endcase
      case ($urandom_range(0, 29))
        0:       polls = MMC_TRIES - 1;
        1:       polls = MMC_TRIES;
        default: polls = $urandom_range(0, 6);
      endcase
      for (int i = 0; i < polls; i++) answer(cmd_error(), $urandom & ~OCR_BUSY_BIT);
      answer(cmd_error(), $urandom | OCR_BUSY_BIT);
    end
    answer(cmd_error(), $urandom);
    answer(cmd_error(), $urandom);
    push_event(ACT_COMPLETE, cmd_error(), $urandom, $urandom, $urandom, $urandom, $urandom);
    answer(cmd_error(), $urandom);
    if (!as_sd)
      push_event(ACT_COMPLETE, cmd_error(), $urandom, $urandom, $urandom, any_word(),
                 $urandom);
    polls = $urandom_range(2, 8);
    for (int i = 0; i < polls; i++)
      push_event(action_e'($urandom_range(1, 3)), $urandom_range(0, 1), $urandom, $urandom,
                 $urandom, $urandom, any_word());
  endtask

  task automatic stray_events(int n);
    for (int i = 0; i < n; i++)
      push_event(action_e'($urandom_range(0, 3)), $urandom_range(0, 1), any_word(),
                 any_word(), any_word(), any_word(), any_word());
  endtask

  task automatic wait_until_quiet();
    while (host_events.size() != 0 || awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // request driver: offers the oldest host event, holds it until taken
  always @(negedge clk_i) begin : request_drive
    if (req_if.valid && req_accepts == req_seen) begin
      // offer still open
    end else begin
      req_seen = req_accepts;
      if (req_gap != 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        req_gap = $urandom_range(0, 9);
        req_if.valid <= 1'b0;
      end else if (host_events.size() != 0) begin
        req_if.valid <= 1'b1;
        req_if.data  <= host_events[0];
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: one long hold-off on request, otherwise bursty stalls
  always @(negedge clk_i) begin : ready_drive
    if (holdoff_go && holdoff_cnt < HOLDOFF_CYCLES) begin
      holdoff_cnt++;
      rsp_if.ready <= 1'b0;
    end else if (rsp_gap != 0) begin
      rsp_gap--;
      rsp_if.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      rsp_gap = $urandom_range(0, 9);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // request transfer: update the model, watch for a hung channel
  always @(posedge clk_i) begin : request_accept
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        action_tally[req_if.data.action]++;
        awaited_results.push_back(sequencer_step(req_if.data));
        void'(host_events.pop_front());
        req_accepts++;
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stalled = 0;
      else
        stalled++;
      if (stalled >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, awaited_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result transfer: compare against the oldest owed result
  always @(posedge clk_i) begin : result_check
    rsp_t  got;
    rsp_t  want;
    string diff;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("result with nothing outstanding: %s", show_result(got));
      end else begin
        want = awaited_results.pop_front();
        status_tally[want.status]++;
        diff = "";
        if (got.status !== want.status) diff = {diff, " status"};
        if (got.cmd_index !== want.cmd_index) diff = {diff, " cmd_index"};
        if (got.cmd_argument !== want.cmd_argument) diff = {diff, " cmd_argument"};
        if (got.resp_kind !== want.resp_kind) diff = {diff, " resp_kind"};
        if (got.data_direction !== want.data_direction) diff = {diff, " data_direction"};
        if (got.data_bytes !== want.data_bytes) diff = {diff, " data_bytes"};
        if (got.card_version !== want.card_version) diff = {diff, " card_version"};
        if (got.is_high_capacity !== want.is_high_capacity)
          diff = {diff, " is_high_capacity"};
        if (got.block_count !== want.block_count) diff = {diff, " block_count"};
        if (got.capacity_bytes !== want.capacity_bytes) diff = {diff, " capacity_bytes"};
        if (diff != "") begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("bad result, fields:%s", diff);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(got));
          end
        end
      end
    end
  end

  // stimulus sequence
  initial begin : stimulus
    logic [23:0] win;
    int          mark;
    rst_ni        = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    rsp_if.ready  = 1'b0;
    host_window   = HOST_WIN_RESET;
    card_phase    = PH_IDLE;
    card_ocr      = 32'd0;
    card_rca      = 16'd0;
    card_ver      = VER_MMC_UNKNOWN;
    card_hc       = 1'b0;
    op_tries      = 7'd0;
    card_blk_log2 = BLK_LOG2_RESET;
    card_blocks   = 33'd0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // completion and block requests while idle are refused
    push_event(ACT_COMPLETE, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_event(ACT_READ, 1'b1, '1, '1, '1, '1, '1);
    push_event(ACT_WRITE, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    // mmc bring-up: ignored if-cond error, op condition rejected, one retry,
    // csd version out of range, largest sizes so capacity saturates
    push_event(ACT_START, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    answer(1'b0, 32'd0);
    answer(1'b1, 32'h0000_01AA);
    answer(1'b0, '1);
    answer(1'b1, '1);
    answer(1'b0, 32'h7FFF_FFFF);
    answer(1'b0, OCR_BUSY_BIT);
    answer(1'b0, 32'd0);
    answer(1'b0, '1);
    push_event(ACT_COMPLETE, 1'b0, '1, '1, '1, 32'd0, 32'd0);
    answer(1'b0, 32'd0);
    push_event(ACT_COMPLETE, 1'b0, 32'd0, 32'd0, 32'd0, '1, 32'd0);
    // scaled address wraps at 32 bits
    push_event(ACT_READ, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, '1);
    push_event(ACT_WRITE, 1'b1, '1, '1, '1, '1, 32'd0);
    answer(1'b1, '1);
    // go-idle error ends in failure, which then sticks
    push_event(ACT_START, 1'b1, '1, '1, '1, '1, '1);
    answer(1'b1, 32'd0);
    answer(1'b0, 32'd0);
    push_event(ACT_READ, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd5);
    // restart in the middle of a sequence
    push_event(ACT_START, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    answer(1'b0, 32'd0);
    push_event(ACT_START, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    answer(1'b0, 32'd0);
    answer(1'b0, 32'h0000_00AA);

    for (int s = 0; s < N_SETTINGS; s++) begin
      case (s)
        0:       win = 24'hFF_FFFF;
        1:       win = 24'h00_0000;
        2:       win = ~HOST_VOLT_MASK;
        6:       win = HOST_WIN_RESET;
        default: win = $urandom;
      endcase
      wait_until_quiet();
      // window write while nothing is in flight
      @(negedge clk_i);
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= win;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      host_window = win;
      windows_set++;
      if (s == 2) holdoff_go = 1'b1;
      if (s == N_SETTINGS - 1) gaps_on = 1'b0;
      @(negedge clk_i) cfg_if.valid <= 1'b0;
      @(posedge clk_i);
      mark = events_queued;
      while (events_queued - mark < EVENTS_PER_SETTING) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: bring_up_card(1'b1);
          4, 5, 6, 7: bring_up_card(1'b0);
          default:    stray_events($urandom_range(2, 8));
        endcase
      end
    end

    wait_until_quiet();
    $display("covered %0d events (start %0d, completion %0d, read %0d, write %0d), %0d windows",
             events_queued, action_tally[ACT_START], action_tally[ACT_COMPLETE],
             action_tally[ACT_READ], action_tally[ACT_WRITE], windows_set);
    $display("results: %0d commands, %0d ready, %0d init failed, %0d refused",
             status_tally[ST_ISSUED], status_tally[ST_READY], status_tally[ST_FAILED],
             status_tally[ST_REFUSED]);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
src/sdinit_pkg.sv
src/sdinit_req_if.sv
src/sdinit_rsp_if.sv
src/sdinit_cfg_if.sv
src/sdinit_in_reg.sv
src/sdinit_ctrl.sv
src/sdinit_out_reg.sv
src/sd_mmc_card_init_sequencer_unit.sv
tb/sv/tb.sv
